[design/nsf_pkg.sv]
// ----------------------------------------------------------------------------
// nsf_pkg: shared types and constants of the NMEA sentence framer
// Character codes, event and phase codes, register map and the channel
// payload structures.
// ----------------------------------------------------------------------------
package nsf_pkg;

  // Sentence limits
  localparam logic [7:0] MAX_CMD_LEN  = 8'd8;
  localparam logic [7:0] MAX_DATA_LEN = 8'd128;
  localparam logic [7:0] CMD_LEN      = 8'd5;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  // Register map, word index
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_TALKER_0 = 3'd0;
  localparam logic [2:0] REG_TALKER_1 = 3'd1;
  localparam logic [2:0] REG_TALKER_2 = 3'd2;
  localparam logic [2:0] REG_TALKER_3 = 3'd3;
  localparam logic [2:0] REG_ENABLE   = 3'd4;

  localparam logic [15:0] TALKER_0_RST = 16'd18256;
  localparam logic [15:0] TALKER_1_RST = 16'd18254;
  localparam logic [15:0] TALKER_2_RST = 16'd18252;
  localparam logic [15:0] TALKER_3_RST = 16'd18241;
  localparam logic [3:0]  ENABLE_RST   = 4'hF;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PAYLOAD      = 3'd1,
    EV_OK           = 3'd2,
    EV_CSUM_ERR     = 3'd3,
    EV_CMD_OVF      = 3'd4,
    EV_PAYLOAD_OVF  = 3'd5,
    EV_BAD_CMD_LEN  = 3'd6,
    EV_UNTRUSTED    = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_CMD  = 3'd1,
    PH_DATA = 3'd2,
    PH_CK1  = 3'd3,
    PH_CK2  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } nsf_in_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [7:0]  payload_length;
    logic [15:0] talker;
    logic [23:0] sentence_type;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
  } nsf_out_t;

  typedef struct packed {
    logic [3:0][15:0] talker_id;
    logic [3:0]       enable;
  } talker_cfg_t;

  // Held request between the input register and the framer
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_req_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else begin
      v = c - CH_A + HEX_TEN;
    end
    return v;
  endfunction

endpackage

[design/nsf_stream_if.sv]
// ----------------------------------------------------------------------------
// nsf_stream_if: valid/ready channel
// Carries one request per accepted handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface nsf_stream_if #(
  parameter type payload_t = nsf_pkg::nsf_in_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/nsf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nsf_cfg_regs: talker configuration registers
// APB-style write and read of the four talker IDs and their enable mask.
// ----------------------------------------------------------------------------
module nsf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output nsf_pkg::talker_cfg_t              cfg
);
  import nsf_pkg::*;

  logic [3:0][15:0] talker_r;
  logic [3:0]       enable_r;
  logic             wr_en;
  logic [2:0]       word;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign word   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      talker_r[0] <= TALKER_0_RST;
      talker_r[1] <= TALKER_1_RST;
      talker_r[2] <= TALKER_2_RST;
      talker_r[3] <= TALKER_3_RST;
      enable_r    <= ENABLE_RST;
    end else if (wr_en) begin
      unique case (word)
        REG_TALKER_0: talker_r[0] <= pwdata[15:0];
        REG_TALKER_1: talker_r[1] <= pwdata[15:0];
        REG_TALKER_2: talker_r[2] <= pwdata[15:0];
        REG_TALKER_3: talker_r[3] <= pwdata[15:0];
        REG_ENABLE:   enable_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (word)
      REG_TALKER_0: prdata = {16'd0, talker_r[0]};
      REG_TALKER_1: prdata = {16'd0, talker_r[1]};
      REG_TALKER_2: prdata = {16'd0, talker_r[2]};
      REG_TALKER_3: prdata = {16'd0, talker_r[3]};
      REG_ENABLE:   prdata = {28'd0, enable_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg.talker_id = talker_r;
  assign cfg.enable    = enable_r;

endmodule

[design/nsf_in_stage.sv]
// ----------------------------------------------------------------------------
// nsf_in_stage: input register
// Holds one received byte until the framer takes it; refills in the same
// cycle so a byte can enter every cycle while the framer keeps taking bytes.
// ----------------------------------------------------------------------------
module nsf_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  nsf_stream_if.sink      in_ch,
  input  logic            take,
  output nsf_pkg::in_req_t req
);
  import nsf_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.payload.rx_byte;
    end
  end

  assign req.valid   = valid_r;
  assign req.rx_byte = byte_r;

endmodule

[design/nsf_framer_core.sv]
// ----------------------------------------------------------------------------
// nsf_framer_core: sentence state machine and result register
// Steps the framing state one byte per unstalled cycle; registers the result.
// ----------------------------------------------------------------------------
module nsf_framer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nsf_pkg::in_req_t     req,
  input  nsf_pkg::talker_cfg_t cfg,
  output logic                 take,
  nsf_stream_if.source         out_ch
);
  import nsf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt, xor_upd;
  logic [7:0]  dsum_r, dsum_nxt, dsum_upd;
  logic [7:0]  count_r, count_nxt, count_upd, count_inc;
  logic [39:0] cmd_r, cmd_nxt;
  logic        out_valid_r;
  nsf_out_t    out_r, res;
  logic        allowed;
  logic        clear;
  logic [7:0]  c;
  logic [7:0]  hex_c;

  assign c         = req.rx_byte;
  assign hex_c     = hex_value(c);
  assign count_inc = count_r + 8'd1;
  assign take      = req.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    allowed = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cfg.enable[i] && cmd_r[39:24] == cfg.talker_id[i]) begin
        allowed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      xor_r   <= 8'd0;
      dsum_r  <= 8'd0;
      count_r <= 8'd0;
      cmd_r   <= 40'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      dsum_r  <= dsum_nxt;
      count_r <= count_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    xor_upd   = xor_r;
    dsum_upd  = dsum_r;
    count_upd = count_r;
    cmd_nxt   = cmd_r;
    clear     = 1'b0;
    res       = '0;
    res.event_res = EV_NONE;

    unique case (phase_r)
      PH_WAIT: begin
        if (c == CH_DOLLAR) begin
          xor_upd   = 8'd0;
          count_upd = 8'd0;
          cmd_nxt   = 40'd0;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if (c != CH_COMMA && c != CH_STAR) begin
          // keep the first five characters only
          case (count_r)
            8'd0: cmd_nxt[39:32] = c;
            8'd1: cmd_nxt[31:24] = c;
            8'd2: cmd_nxt[23:16] = c;
            8'd3: cmd_nxt[15:8]  = c;
            8'd4: cmd_nxt[7:0]   = c;
            default: ;
          endcase
          count_upd = count_inc;
          xor_upd   = xor_r ^ c;
          if (count_inc >= MAX_CMD_LEN) begin
            res.event_res = EV_CMD_OVF;
            phase_nxt     = PH_WAIT;
          end
        end else if (count_r != CMD_LEN) begin
          res.event_res = EV_BAD_CMD_LEN;
          phase_nxt     = PH_WAIT;
        end else begin
          xor_upd   = xor_r ^ c;
          count_upd = 8'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (c == CH_STAR) begin
          phase_nxt = PH_CK1;
        end else if (c == CH_CR) begin
          res.payload_length = count_r;
          if (allowed) begin
            res.event_res = EV_OK;
          end else begin
            res.event_res = EV_UNTRUSTED;
            clear         = 1'b1;
          end
          phase_nxt = PH_WAIT;
        end else begin
          xor_upd           = xor_r ^ c;
          res.payload_byte  = c;
          res.payload_index = count_r[6:0];
          count_upd         = count_inc;
          res.event_res     = EV_PAYLOAD;
          if (count_inc >= MAX_DATA_LEN) begin
            res.event_res      = EV_PAYLOAD_OVF;
            res.payload_length = count_inc;
            phase_nxt          = PH_WAIT;
          end
        end
      end
      PH_CK1: begin
        dsum_upd  = {hex_c[3:0], 4'd0};
        phase_nxt = PH_CK2;
      end
      PH_CK2: begin
        dsum_upd               = dsum_r | hex_c;
        res.received_checksum  = dsum_upd;
        res.payload_length     = count_r;
        if (xor_r == dsum_upd) begin
          if (allowed) begin
            res.event_res = EV_OK;
          end else begin
            res.event_res = EV_UNTRUSTED;
            clear         = 1'b1;
          end
        end else begin
          res.event_res = EV_CSUM_ERR;
        end
        phase_nxt = PH_WAIT;
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    res.talker            = cmd_nxt[39:24];
    res.sentence_type     = cmd_nxt[23:0];
    res.computed_checksum = xor_upd;

    // untrusted talker drops the sums after the result is formed
    xor_nxt   = clear ? 8'd0 : xor_upd;
    dsum_nxt  = clear ? 8'd0 : dsum_upd;
    count_nxt = clear ? 8'd0 : count_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

endmodule

[design/nmea_sentence_framer_unit.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit: NMEA 0183 sentence framer
//
//   port    dir   request                        handshake
//   in_ch   in    one received byte              valid/ready
//   out_ch  out   one event with sentence info   valid/ready
//   cfg_*   in    talker ID / enable registers   APB-style, pready high
//
// One result per byte, one byte per cycle sustained while out_ch does not
// stall. A byte passes two registers: the input register at acceptance, then
// the framing state machine into the result register, where it is valid.
// rst_n is synchronous; it restores the default talkers and the idle phase.
// A stall on out_ch holds the result; an empty input register still takes
// one more byte, then in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  nsf_stream_if.sink                     in_ch,
  nsf_stream_if.source                   out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [nsf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import nsf_pkg::*;

  talker_cfg_t cfg;
  in_req_t     req;
  logic        take;

  nsf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  nsf_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .req   (req)
  );

  nsf_framer_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .cfg    (cfg),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

[tb/nmea_sentence_framer_unit_test.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit_test: self-checking bench for the sentence framer
// Feeds byte streams of whole, broken and noisy sentences through the input
// channel and tracks the framing state in a local model. Every received
// event is compared field by field with the oldest prediction. Talker
// registers are rewritten between phases, and the two channels idle at
// several rates.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_unit_test;
  import nsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  nsf_stream_if #(.payload_t(nsf_in_t))  in_ch ();
  nsf_stream_if #(.payload_t(nsf_out_t)) out_ch ();

  nmea_sentence_framer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Framing model state and register mirror
  phase_t      fr_phase;
  logic [7:0]  fr_csum;
  logic [7:0]  fr_dsum;
  logic [7:0]  fr_count;
  logic [39:0] fr_cmd;
  talker_cfg_t talk_cfg;

  nsf_out_t    pending_events[$];
  int unsigned items_sent;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic logic [7:0] digit_weight(input logic [7:0] c);
    if (c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    return c - CH_A + HEX_TEN;
  endfunction

  function automatic logic talker_trusted(input logic [15:0] who);
    for (int i = 0; i < 4; i++) begin
      if (talk_cfg.enable[i] && who == talk_cfg.talker_id[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the framing model by one byte and return the event it gives
  function automatic nsf_out_t frame_byte(input logic [7:0] c);
    nsf_out_t r;
    logic     clr;
    r   = '0;
    clr = 1'b0;
    r.event_res = EV_NONE;
    case (fr_phase)
      PH_WAIT: begin
        if (c == CH_DOLLAR) begin
          fr_csum  = '0;
          fr_count = '0;
          fr_cmd   = '0;
          fr_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        if (c != CH_COMMA && c != CH_STAR) begin
          if (fr_count < CMD_LEN) begin
            fr_cmd = fr_cmd | ({32'd0, c} << (8 * (4 - int'(fr_count))));
          end
          fr_count = fr_count + 8'd1;
          fr_csum  = fr_csum ^ c;
          if (fr_count >= MAX_CMD_LEN) begin
            r.event_res = EV_CMD_OVF;
            fr_phase    = PH_WAIT;
          end
        end else if (fr_count != CMD_LEN) begin
          r.event_res = EV_BAD_CMD_LEN;
          fr_phase    = PH_WAIT;
        end else begin
          fr_csum  = fr_csum ^ c;
          fr_count = '0;
          fr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (c == CH_STAR) begin
          fr_phase = PH_CK1;
        end else if (c == CH_CR) begin
          r.payload_length = fr_count;
          if (talker_trusted(fr_cmd[39:24])) begin
            r.event_res = EV_OK;
          end else begin
            r.event_res = EV_UNTRUSTED;
            clr = 1'b1;
          end
          fr_phase = PH_WAIT;
        end else begin
          fr_csum         = fr_csum ^ c;
          r.payload_byte  = c;
          r.payload_index = fr_count[6:0];
          fr_count        = fr_count + 8'd1;
          r.event_res     = EV_PAYLOAD;
          if (fr_count >= MAX_DATA_LEN) begin
            r.event_res      = EV_PAYLOAD_OVF;
            r.payload_length = fr_count;
            fr_phase         = PH_WAIT;
          end
        end
      end
      PH_CK1: begin
        fr_dsum  = digit_weight(c) << 4;
        fr_phase = PH_CK2;
      end
      PH_CK2: begin
        fr_dsum             = fr_dsum | digit_weight(c);
        r.received_checksum = fr_dsum;
        r.payload_length    = fr_count;
        if (fr_csum != fr_dsum) begin
          r.event_res = EV_CSUM_ERR;
        end else if (talker_trusted(fr_cmd[39:24])) begin
          r.event_res = EV_OK;
        end else begin
          r.event_res = EV_UNTRUSTED;
          clr = 1'b1;
        end
        fr_phase = PH_WAIT;
      end
      default: begin
        fr_phase = PH_WAIT;
      end
    endcase
    r.talker            = fr_cmd[39:24];
    r.sentence_type     = fr_cmd[23:0];
    r.computed_checksum = fr_csum;
    if (clr) begin
      fr_csum  = '0;
      fr_dsum  = '0;
      fr_count = '0;
      fr_phase = PH_WAIT;
    end
    return r;
  endfunction

  // Enter and leave at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.payload.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_events.push_back(frame_byte(b));
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A + 8'(v) - HEX_TEN;
  endfunction

  task automatic send_checksum(input logic [7:0] v);
    send_byte(hex_char(v[7:4]));
    send_byte(hex_char(v[3:0]));
  endtask

  // Any byte that does not end a field
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CH_COMMA || b == CH_STAR || b == CH_CR);
    return b;
  endfunction

  task automatic wait_idle();
    while (pending_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Write one register, mirror it and read it back
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_access(1'b1, idx, val, rd);
    if (idx == REG_ENABLE) begin
      talk_cfg.enable = val[3:0];
      want = {28'd0, val[3:0]};
    end else begin
      talk_cfg.talker_id[idx] = val[15:0];
      want = {16'd0, val[15:0]};
    end
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, rd);
      error_count++;
    end
  endtask

  task automatic load_talkers(input logic [15:0] t0, input logic [15:0] t1,
                              input logic [15:0] t2, input logic [15:0] t3,
                              input logic [3:0] en);
    wait_idle();
    cfg_write(REG_TALKER_0, {16'hA5A5, t0});
    cfg_write(REG_TALKER_1, {16'h5A5A, t1});
    cfg_write(REG_TALKER_2, 32'(t2));
    cfg_write(REG_TALKER_3, 32'(t3));
    cfg_write(REG_ENABLE, {28'hFFFFFFF, en});
  endtask

  // Mostly well-formed sentences with random content; some broken ones
  task automatic send_random_sentence(input int unsigned max_pay);
    int unsigned shape;
    int unsigned cmd_len;
    int unsigned pay_len;
    int unsigned ending;
    logic [15:0] who;
    logic        star_delim;
    shape = $urandom_range(99);
    if ($urandom_range(7) == 0) begin
      send_byte(8'($urandom_range(255)));
    end
    send_byte(CH_DOLLAR);
    cmd_len = (shape < 85) ? 5 : $urandom_range(9);
    who = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                   : talk_cfg.talker_id[$urandom_range(3)];
    for (int k = 0; k < cmd_len; k++) begin
      if (k < 2) begin
        send_byte(k == 0 ? who[15:8] : who[7:0]);
      end else begin
        send_byte(plain_byte());
      end
    end
    star_delim = ($urandom_range(5) == 0);
    send_byte(star_delim ? CH_STAR : CH_COMMA);
    if (cmd_len != 5) begin
      return;
    end
    if (!star_delim) begin
      pay_len = $urandom_range(max_pay);
      for (int k = 0; k < pay_len; k++) begin
        send_byte(plain_byte());
      end
    end
    ending = $urandom_range(9);
    if (star_delim || ending < 6) begin
      if (!star_delim) begin
        send_byte(CH_STAR);
      end
      if (ending == 5) begin
        send_checksum(8'($urandom_range(255)));
      end else begin
        send_checksum(fr_csum);
      end
    end else if (ending < 9) begin
      send_byte(CH_CR);
    end else begin
      // no validity check on the digits
      send_byte(CH_STAR);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_sentences(input int unsigned n_items, input int unsigned idle_pct,
                               input int unsigned stall_pct);
    int unsigned first;
    first          = items_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent - first < n_items) begin
      send_random_sentence(12);
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GNABC*");
    send_checksum(fr_csum);
    send_text("$AB,");
    send_text("$ABCDEFGH");
    send_text("$QQRMC,");
    send_byte(8'h7F);
    send_byte(CH_CR);
    send_text("$GAXYZ,1*0G");
  endtask

  task automatic test_default_talkers();
    run_sentences(70, 0, 0);
  endtask

  task automatic test_partial_enable();
    load_talkers(16'h4244, 16'h4850, 16'h5449, 16'h5750, 4'b1010);
    run_sentences(70, 48, 0);
  endtask

  task automatic test_all_disabled();
    load_talkers(16'h0000, 16'hFFFF, 16'h4750, 16'h474E, 4'b0000);
    run_sentences(70, 0, 48);
  endtask

  task automatic test_extreme_talkers();
    load_talkers(16'h0000, 16'hFFFF, 16'($urandom_range(65535)), 16'h4741, 4'hF);
    run_sentences(70, 27, 27);
  endtask

  // Fill the payload up to the limit, then carry on with a random sentence
  task automatic test_payload_overflow();
    send_idle_pct  = 0;
    recv_stall_pct = 27;
    send_text("$GPGGA,");
    repeat (MAX_DATA_LEN) send_byte(plain_byte());
    send_random_sentence(12);
  endtask

  // Hold the sender off until every event has arrived
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    repeat (3) begin
      send_random_sentence(6);
      while (pending_events.size() != 0) begin
        @(negedge clk);
      end
    end
    recv_stall_pct = 0;
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : event_check
    nsf_out_t want;
    nsf_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_events.size() == 0) begin
        $error("event %0d with no byte outstanding", got.event_res);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 24'(want.event_res), 24'(got.event_res));
        check_field("payload_byte", 24'(want.payload_byte), 24'(got.payload_byte));
        check_field("payload_index", 24'(want.payload_index), 24'(got.payload_index));
        check_field("payload_length", 24'(want.payload_length), 24'(got.payload_length));
        check_field("talker", 24'(want.talker), 24'(got.talker));
        check_field("sentence_type", want.sentence_type, got.sentence_type);
        check_field("computed_checksum", 24'(want.computed_checksum),
                    24'(got.computed_checksum));
        check_field("received_checksum", 24'(want.received_checksum),
                    24'(got.received_checksum));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nmea_sentence_framer_unit test failed");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.payload.rx_byte = '0;
    out_ch.ready          = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    items_sent            = 0;
    error_count           = 0;
    cycle_count           = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    fr_phase              = PH_WAIT;
    fr_csum               = '0;
    fr_dsum               = '0;
    fr_count              = '0;
    fr_cmd                = '0;
    talk_cfg.talker_id[0] = TALKER_0_RST;
    talk_cfg.talker_id[1] = TALKER_1_RST;
    talk_cfg.talker_id[2] = TALKER_2_RST;
    talk_cfg.talker_id[3] = TALKER_3_RST;
    talk_cfg.enable       = ENABLE_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_default_talkers();
    test_partial_enable();
    test_all_disabled();
    test_extreme_talkers();
    test_payload_overflow();
    test_drain_pause();

    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("nmea_sentence_framer_unit test passed");
    end else begin
      $display("nmea_sentence_framer_unit test failed");
    end
    $finish;
  end

endmodule
